### hw/rtl/rrts_pkg.sv
// Shared types and constants for the round-robin task table scheduler.
`default_nettype none
package rrts_pkg;
    localparam int MAX_TASKS = 256;
    localparam int PID_BITS = 16;
    localparam int SLOT_BITS = $clog2(MAX_TASKS);
    localparam int CNT_BITS = $clog2(MAX_TASKS + 1);

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_FORK = 3'd1;
    localparam logic [2:0] CMD_EXIT = 3'd2;
    localparam logic [2:0] CMD_WAIT = 3'd3;
    localparam logic [2:0] CMD_TICK = 3'd4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_FULL = 3'd1;
    localparam logic [2:0] ST_NOMATCH = 3'd2;
    localparam logic [2:0] ST_INIT = 3'd3;
    localparam logic [2:0] ST_NOREADY = 3'd4;

    localparam logic [1:0] RS_READY = 2'd0;
    localparam logic [1:0] RS_RUNNING = 2'd1;
    localparam logic [1:0] RS_BLOCKED = 2'd2;
    localparam logic [1:0] RS_TERM = 2'd3;

    typedef struct packed {
        logic [2:0] command;
        logic [31:0] ctx_handle;
        logic [15:0] target_pid;
        logic [15:0] parent_pid_in;
        logic [1:0] priority_in;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [15:0] pid_out;
        logic [31:0] ctx_out;
        logic [7:0] running_index;
        logic running_valid;
        logic [8:0] active_tasks;
    } out_item_t;

    typedef struct packed {
        logic [PID_BITS-1:0] pid;
        logic [PID_BITS-1:0] ppid;
        logic [1:0] rs;
        logic wake;
        logic [1:0] prio;
        logic [31:0] ctx;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CUR_RD, S_CUR_WT, S_DISPATCH, S_SCAN, S_SCAN_WT, S_SCAN_CHK,
        S_UPD, S_PAR_RD, S_PAR_WT, S_PAR_CHK, S_DONE
    } state_t;
endpackage
`default_nettype wire

### hw/rtl/round_robin_task_table_scheduler.sv
// Round-robin task table scheduler: table memory and command sequencer.
// Add and unknown commands complete straight from idle; fork, refused commands and an exit
// of a task with no wake flag finish after the current-entry read; exit, wait and tick
// otherwise scan up to task_count entries, one entry at a time in read, wait, check states.
// One transaction in flight; the next is taken no earlier than the edge its result leaves.
// Reset clears counters and running selection; table entries need no clear.
`default_nettype none
module round_robin_task_table_scheduler (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    output logic s_ready,
    input wire rrts_pkg::in_item_t s_data,
    output logic m_valid,
    input wire logic m_ready,
    output rrts_pkg::out_item_t m_data
);
    localparam int SB = rrts_pkg::SLOT_BITS;
    localparam int CB = rrts_pkg::CNT_BITS;
    localparam int PB = rrts_pkg::PID_BITS;

    rrts_pkg::entry_t mem [rrts_pkg::MAX_TASKS];
    rrts_pkg::entry_t rd_q;
    logic [SB-1:0] rd_addr;
    logic rd_en;
    logic wr_en;
    logic [SB-1:0] wr_addr;
    rrts_pkg::entry_t wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q <= mem[rd_addr];
        end
    end

    rrts_pkg::state_t state_reg, state_next;
    rrts_pkg::in_item_t cmd_reg, cmd_next;
    rrts_pkg::entry_t cur_reg, cur_next;
    logic [CB-1:0] task_cnt_reg, task_cnt_next;
    logic [CB-1:0] live_reg, live_next;
    logic [SB-1:0] cur_slot_reg, cur_slot_next;
    logic cur_pres_reg, cur_pres_next;
    logic [PB-1:0] free_pid_reg, free_pid_next;
    logic [SB-1:0] scan_reg, scan_next;
    logic [CB-1:0] left_reg, left_next;
    logic found_reg, found_next;
    logic [SB-1:0] hit_reg, hit_next;
    logic [2:0] st_reg, st_next;
    logic [15:0] pid_res_reg, pid_res_next;
    logic [31:0] ctx_res_reg, ctx_res_next;
    logic m_valid_reg, m_valid_next;
    rrts_pkg::out_item_t m_data_reg, m_data_next;

    logic [PB-1:0] pid_inc;
    logic [SB-1:0] scan_inc;
    logic full;
    logic chk_stop;

    assign pid_inc = free_pid_reg + PB'(1);
    assign full = task_cnt_reg >= CB'(rrts_pkg::MAX_TASKS);
    assign scan_inc = (CB'(scan_reg) + CB'(1) >= task_cnt_reg) ? '0 : scan_reg + SB'(1);
    assign chk_stop = left_reg == CB'(1) ||
        (cmd_reg.command == rrts_pkg::CMD_TICK && rd_q.rs == rrts_pkg::RS_READY) ||
        (cmd_reg.command == rrts_pkg::CMD_EXIT && rd_q.pid == cur_reg.ppid) ||
        (cmd_reg.command == rrts_pkg::CMD_WAIT && cmd_reg.target_pid != '0 &&
         rd_q.pid == PB'(cmd_reg.target_pid));
    assign s_ready = (state_reg == rrts_pkg::S_IDLE) && !(m_valid_reg && !m_ready);
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rrts_pkg::S_IDLE;
            task_cnt_reg <= '0;
            live_reg <= '0;
            cur_slot_reg <= '0;
            cur_pres_reg <= 1'b0;
            free_pid_reg <= PB'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            task_cnt_reg <= task_cnt_next;
            live_reg <= live_next;
            cur_slot_reg <= cur_slot_next;
            cur_pres_reg <= cur_pres_next;
            free_pid_reg <= free_pid_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg <= cmd_next;
        cur_reg <= cur_next;
        scan_reg <= scan_next;
        left_reg <= left_next;
        found_reg <= found_next;
        hit_reg <= hit_next;
        st_reg <= st_next;
        pid_res_reg <= pid_res_next;
        ctx_res_reg <= ctx_res_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rrts_pkg::S_IDLE: begin
                if (s_valid && s_ready) begin
                    state_next = (s_data.command == rrts_pkg::CMD_ADD ||
                        s_data.command > rrts_pkg::CMD_TICK) ? rrts_pkg::S_DONE :
                        rrts_pkg::S_CUR_RD;
                end
            end
            rrts_pkg::S_CUR_RD: state_next = rrts_pkg::S_CUR_WT;
            rrts_pkg::S_CUR_WT: state_next = rrts_pkg::S_DISPATCH;
            rrts_pkg::S_DISPATCH: begin
                priority case (cmd_reg.command)
                    rrts_pkg::CMD_FORK: state_next = rrts_pkg::S_DONE;
                    rrts_pkg::CMD_EXIT: begin
                        if (!cur_pres_reg || rd_q.rs == rrts_pkg::RS_TERM ||
                            rd_q.pid == PB'(1) || !rd_q.wake) begin
                            state_next = rrts_pkg::S_DONE;
                        end else begin
                            state_next = rrts_pkg::S_SCAN;
                        end
                    end
                    rrts_pkg::CMD_WAIT: begin
                        state_next = cur_pres_reg ? rrts_pkg::S_SCAN : rrts_pkg::S_DONE;
                    end
                    default: begin
                        state_next = task_cnt_reg != '0 ? rrts_pkg::S_SCAN :
                            rrts_pkg::S_DONE;
                    end
                endcase
            end
            rrts_pkg::S_SCAN: state_next = rrts_pkg::S_SCAN_WT;
            rrts_pkg::S_SCAN_WT: state_next = rrts_pkg::S_SCAN_CHK;
            rrts_pkg::S_SCAN_CHK: begin
                state_next = chk_stop ? rrts_pkg::S_UPD : rrts_pkg::S_SCAN;
            end
            rrts_pkg::S_UPD: state_next = rrts_pkg::S_DONE;
            rrts_pkg::S_DONE: state_next = rrts_pkg::S_IDLE;
            default: state_next = rrts_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd_next = cmd_reg;
        cur_next = cur_reg;
        task_cnt_next = task_cnt_reg;
        live_next = live_reg;
        cur_slot_next = cur_slot_reg;
        cur_pres_next = cur_pres_reg;
        free_pid_next = free_pid_reg;
        scan_next = scan_reg;
        left_next = left_reg;
        found_next = found_reg;
        hit_next = hit_reg;
        st_next = st_reg;
        pid_res_next = pid_res_reg;
        ctx_res_next = ctx_res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next = m_data_reg;
        rd_en = 1'b0;
        rd_addr = scan_reg;
        wr_en = 1'b0;
        wr_addr = scan_reg;
        wr_data = rd_q;
        unique case (state_reg)
            rrts_pkg::S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd_next = s_data;
                    st_next = rrts_pkg::ST_OK;
                    pid_res_next = '0;
                    ctx_res_next = '0;
                    found_next = 1'b0;
                    if (s_data.command == rrts_pkg::CMD_ADD) begin
                        if (full) begin
                            st_next = rrts_pkg::ST_FULL;
                        end else begin
                            wr_en = 1'b1;
                            wr_addr = SB'(task_cnt_reg);
                            wr_data.pid = free_pid_reg;
                            wr_data.ppid = PB'(s_data.parent_pid_in);
                            wr_data.rs = rrts_pkg::RS_READY;
                            wr_data.wake = 1'b0;
                            wr_data.prio = s_data.priority_in;
                            wr_data.ctx = s_data.ctx_handle;
                            pid_res_next = 16'(free_pid_reg);
                            free_pid_next = pid_inc == '0 ? PB'(1) : pid_inc;
                            task_cnt_next = task_cnt_reg + CB'(1);
                            live_next = live_reg + CB'(1);
                        end
                    end
                end
            end
            rrts_pkg::S_CUR_RD: begin
                rd_en = 1'b1;
                rd_addr = cur_slot_reg;
            end
            rrts_pkg::S_CUR_WT: ;
            rrts_pkg::S_DISPATCH: begin
                cur_next = rd_q;
                left_next = task_cnt_reg;
                scan_next = '0;
                priority case (cmd_reg.command)
                    rrts_pkg::CMD_FORK: begin
                        if (full) begin
                            st_next = rrts_pkg::ST_FULL;
                        end else if (!cur_pres_reg) begin
                            st_next = rrts_pkg::ST_NOMATCH;
                        end else begin
                            wr_en = 1'b1;
                            wr_addr = SB'(task_cnt_reg);
                            wr_data.pid = free_pid_reg;
                            wr_data.ppid = rd_q.pid;
                            wr_data.rs = rrts_pkg::RS_READY;
                            wr_data.wake = 1'b0;
                            wr_data.prio = rd_q.prio;
                            wr_data.ctx = cmd_reg.ctx_handle;
                            pid_res_next = 16'(free_pid_reg);
                            free_pid_next = pid_inc == '0 ? PB'(1) : pid_inc;
                            task_cnt_next = task_cnt_reg + CB'(1);
                            live_next = live_reg + CB'(1);
                        end
                    end
                    rrts_pkg::CMD_EXIT: begin
                        if (!cur_pres_reg || rd_q.rs == rrts_pkg::RS_TERM) begin
                            st_next = rrts_pkg::ST_NOMATCH;
                        end else if (rd_q.pid == PB'(1)) begin
                            st_next = rrts_pkg::ST_INIT;
                        end else if (!rd_q.wake) begin
                            wr_en = 1'b1;
                            wr_addr = cur_slot_reg;
                            wr_data.rs = rrts_pkg::RS_TERM;
                            if (live_reg != '0) begin
                                live_next = live_reg - CB'(1);
                            end
                        end
                    end
                    rrts_pkg::CMD_WAIT: begin
                        if (!cur_pres_reg) begin
                            st_next = rrts_pkg::ST_NOMATCH;
                        end
                    end
                    default: begin
                        ctx_res_next = cmd_reg.ctx_handle;
                        if (task_cnt_reg != '0 && cur_pres_reg) begin
                            wr_en = 1'b1;
                            wr_addr = cur_slot_reg;
                            wr_data.ctx = cmd_reg.ctx_handle;
                            if (rd_q.rs == rrts_pkg::RS_RUNNING) begin
                                wr_data.rs = rrts_pkg::RS_READY;
                            end
                            cur_next = wr_data;
                            scan_next = (CB'(cur_slot_reg) + CB'(1) >= task_cnt_reg) ? '0 :
                                cur_slot_reg + SB'(1);
                        end
                    end
                endcase
            end
            rrts_pkg::S_SCAN: begin
                rd_en = 1'b1;
            end
            rrts_pkg::S_SCAN_WT: ;
            rrts_pkg::S_SCAN_CHK: begin
                hit_next = scan_reg;
                scan_next = scan_inc;
                left_next = left_reg - CB'(1);
                priority case (cmd_reg.command)
                    rrts_pkg::CMD_TICK: begin
                        found_next = rd_q.rs == rrts_pkg::RS_READY;
                        cur_next = rd_q;
                    end
                    rrts_pkg::CMD_EXIT: begin
                        if (rd_q.pid == cur_reg.ppid && rd_q.rs == rrts_pkg::RS_BLOCKED) begin
                            wr_en = 1'b1;
                            wr_data.rs = rrts_pkg::RS_READY;
                        end
                    end
                    default: begin
                        if (rd_q.ppid == cur_reg.pid && (cmd_reg.target_pid == '0 ||
                            rd_q.pid == PB'(cmd_reg.target_pid))) begin
                            found_next = 1'b1;
                            wr_en = 1'b1;
                            wr_data.wake = 1'b1;
                            if (scan_reg == cur_slot_reg) begin
                                cur_next.wake = 1'b1;
                            end
                        end
                    end
                endcase
            end
            rrts_pkg::S_UPD: begin
                priority case (cmd_reg.command)
                    rrts_pkg::CMD_TICK: begin
                        if (found_reg) begin
                            wr_en = 1'b1;
                            wr_addr = hit_reg;
                            wr_data = cur_reg;
                            wr_data.rs = rrts_pkg::RS_RUNNING;
                            cur_slot_next = hit_reg;
                            cur_pres_next = 1'b1;
                            ctx_res_next = cur_reg.ctx;
                        end else begin
                            cur_pres_next = 1'b0;
                            st_next = rrts_pkg::ST_NOREADY;
                        end
                    end
                    rrts_pkg::CMD_EXIT: begin
                        wr_en = 1'b1;
                        wr_addr = cur_slot_reg;
                        wr_data = cur_reg;
                        wr_data.rs = rrts_pkg::RS_TERM;
                        if (live_reg != '0) begin
                            live_next = live_reg - CB'(1);
                        end
                    end
                    default: begin
                        if (found_reg) begin
                            wr_en = 1'b1;
                            wr_addr = cur_slot_reg;
                            wr_data = cur_reg;
                            wr_data.rs = rrts_pkg::RS_BLOCKED;
                        end else begin
                            st_next = rrts_pkg::ST_NOMATCH;
                        end
                    end
                endcase
            end
            rrts_pkg::S_DONE: begin
                m_valid_next = 1'b1;
                m_data_next.status = st_reg;
                m_data_next.pid_out = pid_res_reg;
                m_data_next.ctx_out = ctx_res_reg;
                m_data_next.running_index = 8'(cur_slot_reg);
                m_data_next.running_valid = cur_pres_reg;
                m_data_next.active_tasks = 9'(live_reg);
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(m_data_reg));
    a_done_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == rrts_pkg::S_DONE |-> !m_valid_reg);
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= task_cnt_reg);
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        task_cnt_reg <= CB'(rrts_pkg::MAX_TASKS));
    a_cur_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cur_pres_reg |-> CB'(cur_slot_reg) < task_cnt_reg);
`endif
endmodule
`default_nettype wire
